@@ hdl/tle_pkg.sv @@
`timescale 1ns / 1ps
// Package for the terminal line editor: sizes, key codes and the decoded key command.
// Depends on nothing; used by tle_decode, terminal_line_editor and tle_checker.
package tle_pkg;

  // Line store capacity and the widths derived from it.
  localparam int LINE_CAPACITY = 64;
  localparam int ADDR_W        = $clog2(LINE_CAPACITY);
  localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);
  localparam int LEN_W         = 7;
  localparam int PCNT_W        = 4;
  localparam logic [PCNT_W-1:0] MAX_SEPARATORS = 4'd15;

  // Key codes.
  localparam logic [7:0] KEY_ESC    = 8'h1b;
  localparam logic [7:0] KEY_DEL    = 8'h7f;
  localparam logic [7:0] KEY_CTRL_A = 8'h01;
  localparam logic [7:0] KEY_CTRL_E = 8'h05;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_LF     = 8'h0a;
  localparam logic [7:0] KEY_CR     = 8'h0d;
  localparam logic [7:0] KEY_LBRACK = 8'h5b;
  localparam logic [7:0] KEY_QMARK  = 8'h3f;
  localparam logic [7:0] KEY_SEMI   = 8'h3b;
  localparam logic [7:0] KEY_LEFT   = 8'h44;
  localparam logic [7:0] KEY_RIGHT  = 8'h43;
  localparam logic [7:0] KEY_TILDE  = 8'h7e;
  localparam logic [7:0] KEY_SPACE  = 8'h20;
  localparam logic [7:0] KEY_ZERO   = 8'h30;
  localparam logic [7:0] KEY_NINE   = 8'h39;

  // Escape parser phases.
  typedef enum logic [1:0] {
    ESC_TEXT   = 2'd0,
    ESC_SEEN   = 2'd1,
    ESC_CSI    = 2'd2,
    ESC_PARAMS = 2'd3
  } esc_phase_t;

  // Editing action requested by one key byte.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LINE_END,
    ACT_INSERT,
    ACT_DELETE_BACK,
    ACT_DELETE_AT,
    ACT_HOME,
    ACT_END,
    ACT_CLEAR,
    ACT_LEFT,
    ACT_RIGHT
  } tle_action_t;

  // Decoder result handed to the editing controller.
  typedef struct packed {
    tle_action_t       action;
    esc_phase_t        phase_next;
    logic [PCNT_W-1:0] pcount_next;
  } tle_cmd_t;

endpackage

@@ hdl/tle_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port and one registered read port.
// Depends on nothing.
module tle_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/tle_decode.sv @@
`timescale 1ns / 1ps
// Key decoder: classifies one keyboard byte against the escape parser state.
// Depends on tle_pkg.
module tle_decode (
  input  logic [7:0]                 key_byte,
  input  logic                       end_of_input,
  input  tle_pkg::esc_phase_t        phase,
  input  logic [tle_pkg::PCNT_W-1:0] pcount,
  output tle_pkg::tle_cmd_t          cmd
);
  import tle_pkg::*;

  // Handling of a byte inside the parameter part of a control sequence.
  function automatic tle_cmd_t param_byte(logic [7:0] c, logic [PCNT_W-1:0] pc);
    tle_cmd_t r;
    r.action      = ACT_NONE;
    r.phase_next  = ESC_PARAMS;
    r.pcount_next = pc;
    if (c == KEY_SEMI && pc < MAX_SEPARATORS) begin
      r.pcount_next = pc + 1'b1;
    end else if (c >= KEY_ZERO && c <= KEY_NINE) begin
      r.pcount_next = pc;
    end else begin
      // Final byte closes the sequence; unknown ones do nothing.
      r.phase_next = ESC_TEXT;
      if (c == KEY_LEFT) begin
        r.action = ACT_LEFT;
      end else if (c == KEY_RIGHT) begin
        r.action = ACT_RIGHT;
      end else if (c == KEY_TILDE) begin
        r.action = ACT_DELETE_AT;
      end
    end
    return r;
  endfunction

  always_comb begin
    cmd.action      = ACT_NONE;
    cmd.phase_next  = phase;
    cmd.pcount_next = pcount;
    if (end_of_input || key_byte == KEY_LF || key_byte == KEY_CR) begin
      // Line end overrides any escape sequence in progress.
      cmd.action      = ACT_LINE_END;
      cmd.phase_next  = ESC_TEXT;
      cmd.pcount_next = '0;
    end else begin
      case (phase)
        ESC_TEXT: begin
          if (key_byte == KEY_ESC) begin
            cmd.phase_next = ESC_SEEN;
          end else if (key_byte == KEY_DEL) begin
            cmd.action = ACT_DELETE_BACK;
          end else if (key_byte >= KEY_SPACE && key_byte <= KEY_TILDE) begin
            cmd.action = ACT_INSERT;
          end else if (key_byte == KEY_CTRL_A) begin
            cmd.action = ACT_HOME;
          end else if (key_byte == KEY_CTRL_E) begin
            cmd.action = ACT_END;
          end else if (key_byte == KEY_CTRL_U) begin
            cmd.action = ACT_CLEAR;
          end
        end
        ESC_SEEN: begin
          cmd.phase_next = (key_byte == KEY_LBRACK) ? ESC_CSI : ESC_TEXT;
        end
        ESC_CSI: begin
          // An optional question mark may open the parameters.
          if (key_byte == KEY_QMARK) begin
            cmd.phase_next  = ESC_PARAMS;
            cmd.pcount_next = '0;
          end else begin
            cmd = param_byte(key_byte, '0);
          end
        end
        ESC_PARAMS: begin
          cmd = param_byte(key_byte, pcount);
        end
        default: begin
          cmd.phase_next = ESC_TEXT;
        end
      endcase
    end
  end

endmodule

@@ hdl/terminal_line_editor.sv @@
`timescale 1ns / 1ps
// Terminal line editor: keeps an editable line of up to LINE_CAPACITY bytes in a RAM.
// Depends on tle_pkg, tle_decode and tle_ram.
//
// The editor takes one keyboard byte per request and, on CR, LF or end of input,
// returns the finished line as one result per byte (a single result with line_empty
// set for an empty line). Cursor moves, escape bytes, ignored bytes and dropped
// inserts finish without leaving the idle state. An insert moves the bytes from the
// cursor to the end of the line up one place and then writes the new byte at the
// cursor; a delete before or at the cursor moves the bytes behind it down one place.
// The line RAM moves one byte per cycle through its single write port. A line end
// reads each byte of the line from the RAM, then loads it into the output register,
// waiting while the output stalls. Requests are refused while an edit or an emission
// is busy; a request that gives no result may be taken while the last result waits.
module terminal_line_editor (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] key_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] line_char,
  output logic [6:0] line_length,
  output logic       line_empty,
  output logic       last_of_line,
  output logic       overflowed,
  output logic       ended_by_eof
);
  import tle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_EMIT_RD,
    S_EMIT_WAIT
  } state_t;

  state_t            state;
  esc_phase_t        escape_phase;
  logic [PCNT_W-1:0] param_count;
  logic [CNT_W-1:0]  cursor;
  logic [CNT_W-1:0]  length;
  logic              overflow_seen;
  logic [CNT_W-1:0]  idx;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;
  logic [7:0]        ins_byte;
  logic [CNT_W-1:0]  emit_len;
  logic              emit_ovf;
  logic              emit_eof;
  logic [CNT_W-1:0]  emit_idx;

  tle_cmd_t          cmd;
  logic              in_fire;
  logic              out_free;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  tle_decode u_decode (
    .key_byte     (key_byte),
    .end_of_input (end_of_input),
    .phase        (escape_phase),
    .pcount       (param_count),
    .cmd          (cmd)
  );

  tle_ram #(
    .DEPTH (LINE_CAPACITY),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // RAM access: a pending move write takes priority over the new byte.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx[ADDR_W-1:0] - 1'b1;
    case (state)
      S_SHIFT_UP: begin
        if (pend) begin
          ram_we = 1'b1;
        end else if (idx == cursor) begin
          ram_we    = 1'b1;
          ram_waddr = cursor[ADDR_W-1:0];
          ram_wdata = ins_byte;
        end
        ram_re = (idx > cursor);
      end
      S_SHIFT_DN: begin
        ram_we    = pend;
        ram_re    = (idx < length);
        ram_raddr = idx[ADDR_W-1:0];
      end
      S_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = emit_idx[ADDR_W-1:0];
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // Control state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      escape_phase  <= ESC_TEXT;
      param_count   <= '0;
      cursor        <= '0;
      length        <= '0;
      overflow_seen <= 1'b0;
      pend          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // While a byte of the line waits, the output register is reloaded instead.
      if (out_valid && out_ready && state != S_EMIT_WAIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            escape_phase <= cmd.phase_next;
            param_count  <= cmd.pcount_next;
            pend         <= 1'b0;
            case (cmd.action)
              ACT_LINE_END: begin
                emit_len      <= length;
                emit_ovf      <= overflow_seen;
                emit_eof      <= end_of_input;
                emit_idx      <= '0;
                cursor        <= '0;
                length        <= '0;
                overflow_seen <= 1'b0;
                state         <= S_EMIT_RD;
              end
              ACT_INSERT: begin
                if (length >= CNT_W'(LINE_CAPACITY)) begin
                  overflow_seen <= 1'b1;
                end else begin
                  idx      <= length;
                  ins_byte <= key_byte;
                  state    <= S_SHIFT_UP;
                end
              end
              ACT_DELETE_BACK: begin
                if (cursor != '0) begin
                  cursor <= cursor - 1'b1;
                  idx    <= cursor;
                  state  <= S_SHIFT_DN;
                end
              end
              ACT_DELETE_AT: begin
                if (cursor < length) begin
                  idx   <= cursor + 1'b1;
                  state <= S_SHIFT_DN;
                end
              end
              ACT_HOME:  cursor <= '0;
              ACT_END:   cursor <= length;
              ACT_CLEAR: begin
                cursor <= '0;
                length <= '0;
              end
              ACT_LEFT: begin
                if (cursor != '0) begin
                  cursor <= cursor - 1'b1;
                end
              end
              ACT_RIGHT: begin
                if (cursor < length) begin
                  cursor <= cursor + 1'b1;
                end
              end
              default: begin
                cursor <= cursor;
              end
            endcase
          end
        end
        // Open a gap at the cursor, moving bytes up from the end of the line.
        S_SHIFT_UP: begin
          if (idx > cursor) begin
            pend      <= 1'b1;
            pend_addr <= idx[ADDR_W-1:0];
            idx       <= idx - 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              cursor <= cursor + 1'b1;
              length <= length + 1'b1;
              state  <= S_IDLE;
            end
          end
        end
        // Close the gap, moving bytes down one place.
        S_SHIFT_DN: begin
          if (idx < length) begin
            pend      <= 1'b1;
            pend_addr <= idx[ADDR_W-1:0] - 1'b1;
            idx       <= idx + 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              length <= length - 1'b1;
              state  <= S_IDLE;
            end
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WAIT;
        end
        // Load one byte of the finished line into the output register.
        S_EMIT_WAIT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            line_char    <= (emit_len == '0) ? 8'h00 : ram_rdata;
            line_length  <= LEN_W'(emit_len);
            line_empty   <= (emit_len == '0);
            overflowed   <= emit_ovf;
            ended_by_eof <= emit_eof;
            if (emit_idx + 1'b1 >= emit_len) begin
              last_of_line <= 1'b1;
              state        <= S_IDLE;
            end else begin
              last_of_line <= 1'b0;
              emit_idx     <= emit_idx + 1'b1;
              state        <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/tle_checker.sv @@
`timescale 1ns / 1ps
// Port checker for the terminal line editor, bound to the top level.
// Depends on tle_pkg and terminal_line_editor.
module tle_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] key_byte,
  input logic       end_of_input,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] line_char,
  input logic [6:0] line_length,
  input logic       line_empty,
  input logic       last_of_line,
  input logic       overflowed,
  input logic       ended_by_eof
);
  import tle_pkg::*;

  // A waiting request holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(key_byte) && $stable(end_of_input))
    else $error("request changed while waiting");

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(line_char) && $stable(line_length)
      && $stable(line_empty) && $stable(last_of_line) && $stable(overflowed)
      && $stable(ended_by_eof))
    else $error("result changed while stalled");

  // An empty line is a single zero result.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && line_empty |-> last_of_line && line_char == 8'h00 && line_length == 7'd0)
    else $error("malformed empty line result");

  // The reported length never exceeds the capacity and is non-zero for a real line.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_length <= 7'(LINE_CAPACITY) && (line_empty || line_length != 7'd0))
    else $error("line length out of range");

  // No new request is taken while a line is still being emitted.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_line |-> !in_ready)
    else $error("request accepted during line emission");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (.*);
